/* rtl/lfpd_pkg.sv */
// ============================================================================
// lfpd_pkg
// Shared types and constants of the line follower PID drive.
// ============================================================================
package lfpd_pkg;

   localparam int SENSOR_COUNT = 6;
   localparam int LEFT_OFFSET  = 10;
   localparam int TENTH_Q15    = 3277;
   localparam int HALF_Q15     = 16384;
   localparam int INT_LIMIT    = 21474836;
   localparam int SAMPLE_W     = 12;
   localparam int IDX_W        = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int DIV_N_W      = 32;
   localparam int DIV_D_W      = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_TIME_STEP = 3'd3,
      CSR_INV_STEP  = 3'd4,
      CSR_MAX_SPEED = 3'd5,
      CSR_POS_MIN   = 3'd6,
      CSR_POS_MAX   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACCUM,
      OP_DIV1_START,
      OP_DIS,
      OP_DIV2_START,
      OP_ERR,
      OP_INTEG,
      OP_CLAMP_I,
      OP_PROP,
      OP_DERIV1,
      OP_DERIV2,
      OP_INTG_TERM,
      OP_PWM,
      OP_TURN,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

/* rtl/lfpd_if.sv */
// ============================================================================
// lfpd channel interfaces
// Request, response and register-write channels with valid/ready.
// ============================================================================
interface lfpd_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] sample_0;
   logic [11:0] sample_1;
   logic [11:0] sample_2;
   logic [11:0] sample_3;
   logic [11:0] sample_4;
   logic [11:0] sample_5;
   modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   sample_5, input ready);
   modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                 sample_5, output ready);
endinterface

interface lfpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic signed [15:0] line_error;
   modport source (output valid, left_speed, right_speed, line_error, input ready);
   modport sink (input valid, left_speed, right_speed, line_error, output ready);
endinterface

interface lfpd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/lfpd_divider.sv */
// ============================================================================
// lfpd_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module lfpd_divider
   import lfpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic [DIV_N_W-1:0] quotient,
   output logic               done
);

   localparam int CNT_W = $clog2(DIV_N_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W:0]   shifted;
   logic               fits;

   assign shifted = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_N_W - 1);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_D_W'(shifted - {1'b0, den_ff}) : DIV_D_W'(shifted);
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/lfpd_datapath.sv */
// ============================================================================
// lfpd_datapath
// Registers, centroid accumulator, PID arithmetic and motor mapping.
// ============================================================================
module lfpd_datapath
   import lfpd_pkg::*;
#(
   parameter int POS_INNER      = 1000,
   parameter int POS_MIDDLE     = 2000,
   parameter int POS_OUTER      = 3000,
   parameter int LOST_SUM_LIMIT = 10000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [SAMPLE_W-1:0]   samples [SENSOR_COUNT],
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic signed [15:0]    left_speed,
   output logic signed [15:0]    right_speed,
   output logic signed [15:0]    line_error
);

   localparam logic signed [15:0] POS_L0 = 16'(-(POS_OUTER + LEFT_OFFSET));
   localparam logic signed [15:0] POS_L1 = 16'(-(POS_MIDDLE + LEFT_OFFSET));
   localparam logic signed [15:0] POS_L2 = 16'(-(POS_INNER + LEFT_OFFSET));
   localparam logic signed [15:0] POS_R0 = 16'(POS_INNER);
   localparam logic signed [15:0] POS_R1 = 16'(POS_MIDDLE);
   localparam logic signed [15:0] POS_R2 = 16'(POS_OUTER);
   localparam logic [14:0]        LOST_LIM = 15'(LOST_SUM_LIMIT);

   // configuration
   logic [15:0]        gain_p_ff, gain_i_ff, gain_d_ff, time_step_ff, inv_step_ff;
   logic [14:0]        max_speed_ff;
   logic signed [15:0] pos_min_ff, pos_max_ff;
   // loop state
   logic signed [15:0] prev_ff;
   logic signed [25:0] integ_ff;
   // working registers
   logic [SAMPLE_W-1:0] samp_ff [SENSOR_COUNT];
   logic signed [29:0] sum_ff;
   logic [14:0]        ssum_ff;
   logic               neg_ff;
   logic signed [14:0] dis_ff;
   logic               span_zero_ff, lost_ff;
   logic signed [15:0] e_ff;
   logic signed [32:0] prodi_ff;
   logic signed [25:0] inew_ff;
   logic signed [16:0] d_ff;
   logic signed [55:0] acc_ff;
   logic signed [33:0] dterm_ff;
   logic               p_pos_ff, p_neg_ff, p_hi_ff;
   logic [14:0]        opnd_ff;
   logic signed [32:0] tprod_ff;
   logic signed [15:0] left_ff, right_ff, err_out_ff;

   // divider
   logic               div_start;
   logic [DIV_N_W-1:0] div_num, div_q;
   logic [DIV_D_W-1:0] div_den;
   logic               div_done;

   lfpd_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_q),
      .done     (div_done)
   );

   assign status.div_done = div_done;

   // centroid term
   logic signed [15:0]  pos_sel;
   logic [SAMPLE_W-1:0] samp_sel;
   logic signed [27:0]  pos_prod;

   always_comb begin
      case (cmd.idx)
         3'd0:    pos_sel = POS_L0;
         3'd1:    pos_sel = POS_L1;
         3'd2:    pos_sel = POS_L2;
         3'd3:    pos_sel = POS_R0;
         3'd4:    pos_sel = POS_R1;
         default: pos_sel = POS_R2;
      endcase
   end

   assign samp_sel = (cmd.idx < IDX_W'(SENSOR_COUNT)) ? samp_ff[cmd.idx] : '0;
   assign pos_prod = $signed({1'b0, samp_sel}) * pos_sel;

   // divider operands
   logic [29:0]        sum_mag;
   logic signed [17:0] diff;
   logic [17:0]        diff_mag;
   logic signed [16:0] span;
   logic [16:0]        span_mag;

   assign sum_mag  = sum_ff[29] ? 30'(-sum_ff) : 30'(sum_ff);
   assign diff     = 18'(dis_ff) - 18'(pos_min_ff);
   assign diff_mag = diff[17] ? 18'(-diff) : 18'(diff);
   assign span     = 17'(pos_max_ff) - 17'(pos_min_ff);
   assign span_mag = span[16] ? 17'(-span) : 17'(span);

   always_comb begin
      div_start = 1'b0;
      div_num   = 32'(sum_mag);
      div_den   = {1'b0, ssum_ff};
      if (cmd.op == OP_DIV1_START) begin
         div_start = 1'b1;
      end else if (cmd.op == OP_DIV2_START) begin
         div_start = 1'b1;
         div_num   = {diff_mag[15:0], 16'd0};
         div_den   = span_mag[15:0];
      end
   end

   // error
   logic signed [33:0] q_signed, q_off;
   logic signed [15:0] e_calc;

   assign q_signed = neg_ff ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
   assign q_off    = q_signed - 34'sd32768;

   always_comb begin
      if (lost_ff)
         e_calc = (prev_ff > 16'sd0) ? 16'sh7fff : 16'sh8000;
      else if (span_zero_ff)
         e_calc = '0;
      else if (q_off > 34'sd32767)
         e_calc = 16'sh7fff;
      else if (q_off < -34'sd32768)
         e_calc = 16'sh8000;
      else
         e_calc = 16'(q_off);
   end

   // PID terms
   logic signed [33:0] isum;
   logic signed [25:0] iclamp;
   logic signed [50:0] dprod;
   logic signed [41:0] iprod;
   logic signed [24:0] pclamp;
   logic signed [16:0] p_val, p_mag;

   assign isum = 34'(integ_ff) + 34'(prodi_ff);
   assign iclamp = (isum > 34'(INT_LIMIT))  ? 26'(INT_LIMIT) :
                   (isum < -34'(INT_LIMIT)) ? 26'(-INT_LIMIT) : 26'(isum);
   assign dprod = dterm_ff * $signed({1'b0, inv_step_ff});
   assign iprod = $signed({1'b0, gain_i_ff}) * inew_ff;
   assign pclamp = (acc_ff > 56'sd8388608)  ? 25'sd8388608 :
                   (acc_ff < -56'sd8388608) ? -25'sd8388608 : 25'(acc_ff);
   assign p_val = 17'(pclamp >>> 8);
   assign p_mag = p_val[16] ? -p_val : p_val;

   // turn mapping
   logic signed [16:0] slope;
   logic signed [18:0] fdiv;
   logic signed [19:0] inner;
   logic signed [15:0] inner_sat, vspeed;

   assign slope  = $signed({2'b00, max_speed_ff}) - 17'sd3277;
   assign fdiv   = 19'(tprod_ff >>> 14);
   assign inner  = p_hi_ff ? -(20'sd3277 + 20'(fdiv))
                           : 20'($signed({1'b0, max_speed_ff})) - 20'(fdiv);
   assign inner_sat = (inner > 20'sd32767) ? 16'sh7fff :
                      (inner < -20'sd32768) ? 16'sh8000 : 16'(inner);
   assign vspeed = $signed({1'b0, max_speed_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 16'd256;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         time_step_ff <= 16'd655;
         inv_step_ff  <= 16'd100;
         max_speed_ff <= 15'd16384;
         pos_min_ff   <= -16'sd3010;
         pos_max_ff   <= 16'sd3000;
         prev_ff      <= '0;
         integ_ff     <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_GAIN_P:    gain_p_ff    <= csr_data;
               CSR_GAIN_I:    gain_i_ff    <= csr_data;
               CSR_GAIN_D:    gain_d_ff    <= csr_data;
               CSR_TIME_STEP: time_step_ff <= csr_data;
               CSR_INV_STEP:  inv_step_ff  <= csr_data;
               CSR_MAX_SPEED: max_speed_ff <= csr_data[14:0];
               CSR_POS_MIN:   pos_min_ff   <= csr_data;
               CSR_POS_MAX:   pos_max_ff   <= csr_data;
               default:       ;
            endcase
         end
         if (cmd.op == OP_FINISH) begin
            prev_ff  <= e_ff;
            integ_ff <= inew_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            samp_ff <= samples;
            sum_ff  <= '0;
            ssum_ff <= '0;
         end
         OP_ACCUM: begin
            sum_ff  <= sum_ff + 30'(pos_prod);
            ssum_ff <= ssum_ff + 15'(samp_sel);
         end
         OP_DIV1_START: neg_ff <= sum_ff[29];
         OP_DIS: begin
            if (ssum_ff == '0)
               dis_ff <= '0;
            else
               dis_ff <= neg_ff ? -15'(div_q) : 15'(div_q);
         end
         OP_DIV2_START: begin
            neg_ff       <= diff[17] ^ span[16];
            span_zero_ff <= (span == '0);
            lost_ff      <= ssum_ff > LOST_LIM;
         end
         OP_ERR:     e_ff <= e_calc;
         OP_INTEG:   prodi_ff <= e_ff * $signed({1'b0, time_step_ff});
         OP_CLAMP_I: begin
            inew_ff <= iclamp;
            d_ff    <= 17'(e_ff) - 17'(prev_ff);
         end
         OP_PROP:      acc_ff   <= 56'($signed({1'b0, gain_p_ff}) * e_ff);
         OP_DERIV1:    dterm_ff <= $signed({1'b0, gain_d_ff}) * d_ff;
         OP_DERIV2:    acc_ff   <= acc_ff + 56'(dprod);
         OP_INTG_TERM: acc_ff   <= acc_ff + 56'(iprod >>> 16);
         OP_PWM: begin
            p_pos_ff <= p_val > 17'sd0;
            p_neg_ff <= p_val < 17'sd0;
            p_hi_ff  <= p_mag > 17'sd16384;
            opnd_ff  <= (p_mag > 17'sd16384) ? 15'(p_mag - 17'sd16384) : 15'(p_mag);
         end
         OP_TURN: tprod_ff <= $signed({1'b0, opnd_ff}) * slope;
         OP_FINISH: begin
            err_out_ff <= e_ff;
            left_ff    <= p_pos_ff ? inner_sat : vspeed;
            right_ff   <= p_neg_ff ? inner_sat : vspeed;
         end
         default: ;
      endcase
   end

   assign left_speed  = left_ff;
   assign right_speed = right_ff;
   assign line_error  = err_out_ff;

endmodule

/* rtl/lfpd_ctrl.sv */
// ============================================================================
// lfpd_ctrl
// Sequencer for one sensor frame; owns the request and response handshakes.
// ============================================================================
module lfpd_ctrl
   import lfpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_ACCUM, S_DIV1_START, S_DIV1_WAIT, S_DIS, S_DIV2_WAIT, S_ERR,
      S_INTEG, S_CLAMP_I, S_PROP, S_DERIV1, S_DERIV2, S_INTG_TERM, S_PWM,
      S_TURN, S_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.idx      = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               idx_in   = '0;
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            cmd.op = OP_ACCUM;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(SENSOR_COUNT - 1))
               state_in = S_DIV1_START;
         end
         S_DIV1_START: begin
            cmd.op   = OP_DIV1_START;
            state_in = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: if (status.div_done) state_in = S_DIS;
         S_DIS: begin
            cmd.op   = OP_DIS;
            state_in = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            // first cycle here launches the second divide
            if (idx_ff != '0) begin
               cmd.op = OP_DIV2_START;
               idx_in = '0;
            end else if (status.div_done) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.op   = OP_ERR;
            state_in = S_INTEG;
         end
         S_INTEG: begin
            cmd.op   = OP_INTEG;
            state_in = S_CLAMP_I;
         end
         S_CLAMP_I: begin
            cmd.op   = OP_CLAMP_I;
            state_in = S_PROP;
         end
         S_PROP: begin
            cmd.op   = OP_PROP;
            state_in = S_DERIV1;
         end
         S_DERIV1: begin
            cmd.op   = OP_DERIV1;
            state_in = S_DERIV2;
         end
         S_DERIV2: begin
            cmd.op   = OP_DERIV2;
            state_in = S_INTG_TERM;
         end
         S_INTG_TERM: begin
            cmd.op   = OP_INTG_TERM;
            state_in = S_PWM;
         end
         S_PWM: begin
            cmd.op   = OP_PWM;
            state_in = S_TURN;
         end
         S_TURN: begin
            cmd.op   = OP_TURN;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_load_needs_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> req_valid)
      else $error("frame loaded without a valid request");
   a_finish_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |=> rsp_valid_ff)
      else $error("finished frame did not raise rsp valid");
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while frame in flight");
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DIV1_WAIT || state_ff == S_DIV2_WAIT))
      else $error("divider finished outside a wait state");
`endif

endmodule

/* rtl/line_follower_pid_drive_top.sv */
// ============================================================================
// line_follower_pid_drive_top
// PID line follower: sensor centroid to differential motor speeds.
// ============================================================================
// Usage:
//  req : one request per sensor frame, six 12-bit reflectance samples,
//        leftmost first. Taken when valid and ready are high at a clock edge.
//  rsp : one response per request: left/right motor speed and the line
//        error, all signed Q1.15.
//  csr : register writes (index 0..7: gain_p, gain_i, gain_d, time_step,
//        inverse_time_step, max_speed, position_min, position_max). Always
//        ready; write only while no request is in flight.
// Flow: two passes of the shared restoring divider (centroid, then error
//  normalization), after the centroid accumulation over the six samples
//  and before ten PID/mapping steps. One request at a time: the next is
//  taken only once the current one has finished its run.
// Stall: the response stays in its output register until taken; the next
//  request is accepted meanwhile, and its own result waits at the end of
//  its run until the register frees up.
// Reset (synchronous, active high): registers return to their defaults,
//  previous error and integral clear, no response pending.
module line_follower_pid_drive_top
   import lfpd_pkg::*;
#(
   parameter int POS_INNER      = 1000,
   parameter int POS_MIDDLE     = 2000,
   parameter int POS_OUTER      = 3000,
   parameter int LOST_SUM_LIMIT = 10000
) (
   input logic       clock,
   input logic       reset,
   lfpd_req_if.sink  req,
   lfpd_rsp_if.source rsp,
   lfpd_csr_if.sink  csr
);

   cmd_type             cmd;
   status_type          status;
   logic [SAMPLE_W-1:0] samples [SENSOR_COUNT];

   assign samples[0] = req.sample_0;
   assign samples[1] = req.sample_1;
   assign samples[2] = req.sample_2;
   assign samples[3] = req.sample_3;
   assign samples[4] = req.sample_4;
   assign samples[5] = req.sample_5;

   // register port never stalls
   assign csr.ready = 1'b1;

   lfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfpd_datapath #(
      .POS_INNER      (POS_INNER),
      .POS_MIDDLE     (POS_MIDDLE),
      .POS_OUTER      (POS_OUTER),
      .LOST_SUM_LIMIT (LOST_SUM_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .samples     (samples),
      .csr_we      (csr.valid),
      .csr_index   (csr.index),
      .csr_data    (csr.data),
      .left_speed  (rsp.left_speed),
      .right_speed (rsp.right_speed),
      .line_error  (rsp.line_error)
   );

endmodule

/* dv/tb.sv */
// ============================================================================
// tb
// Testbench of the line follower PID drive. Sensor frames go in, and each
// response is checked field by field against a built-in bit-exact predictor
// that keeps its own error history, integral and register copies.
// ============================================================================
`timescale 1ns / 100ps

module tb;
   import lfpd_pkg::*;

   localparam int LATENCY = 85;
   localparam longint CYCLE_LIMIT = 1200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfpd_req_if req ();
   lfpd_rsp_if rsp ();
   lfpd_csr_if csr ();

   line_follower_pid_drive_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #4 clock = ~clock;

   typedef struct packed {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [15:0] line_error;
   } drive_out_t;

   // predictor state and register copies
   longint gain_p_r, gain_i_r, gain_d_r, step_r, inv_step_r, vmax_r, pmin_r, pmax_r;
   longint prev_err, integ_acc;

   drive_out_t speed_queue[$];
   int  mismatches;
   bit  failed;
   bit  idle_on;          // random idling allowed
   bit  hold_rsp;         // long receiver hold-off request
   longint cycles;

   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && ((a < 0) != (b < 0))) q -= 1;
      return q;
   endfunction

   function automatic longint clampl(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   // speed of the wheel on the inside of the turn
   function automatic longint inner_wheel(longint p, longint v);
      longint slope;
      slope = v - TENTH_Q15;
      if (p <= HALF_Q15) return v - fdiv(p * slope, HALF_Q15);
      return -(TENTH_Q15 + fdiv((p - HALF_Q15) * slope, HALF_Q15));
   endfunction

   function automatic drive_out_t predict_drive(logic [11:0] s[6]);
      longint pos[6];
      longint wsum, ssum, cen, err, span, integ, pwm, p, l, r;
      drive_out_t o;
      pos = '{-3010, -2010, -1010, 1000, 2000, 3000};
      wsum = 0; ssum = 0; cen = 0;
      for (int i = 0; i < 6; i++) begin
         ssum += s[i];
         wsum += longint'(s[i]) * pos[i];
      end
      if (ssum != 0) cen = wsum / ssum;
      if (ssum > 10000) begin
         // line lost: hold the side it was last seen on
         err = prev_err > 0 ? 32767 : -32768;
      end else begin
         span = pmax_r - pmin_r;
         if (span == 0) err = 0;
         else err = clampl((cen - pmin_r) * 65536 / span - 32768, -32768, 32767);
      end
      integ = clampl(integ_acc + err * step_r, -INT_LIMIT, INT_LIMIT);
      pwm = gain_p_r * err + gain_d_r * (err - prev_err) * inv_step_r
            + fdiv(gain_i_r * integ, 65536);
      pwm = clampl(pwm, -(64'sd1 <<< 23), 64'sd1 <<< 23);
      p = fdiv(pwm, 256);
      if (p > 0) begin
         r = vmax_r; l = inner_wheel(p, vmax_r);
      end else if (p < 0) begin
         l = vmax_r; r = inner_wheel(-p, vmax_r);
      end else begin
         l = vmax_r; r = vmax_r;
      end
      prev_err = err;
      integ_acc = integ;
      o.left_speed = 16'(clampl(l, -32768, 32767));
      o.right_speed = 16'(clampl(r, -32768, 32767));
      o.line_error = 16'(err);
      return o;
   endfunction

   // here, valid drops only when the sender actually idles
   task automatic idle_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // sends one sensor frame and records its expected drive
   task automatic send_frame(logic [11:0] s0, s1, s2, s3, s4, s5);
      logic [11:0] s[6];
      s = '{s0, s1, s2, s3, s4, s5};
      idle_gap();
      req.valid <= 1'b1;
      req.sample_0 <= s0; req.sample_1 <= s1; req.sample_2 <= s2;
      req.sample_3 <= s3; req.sample_4 <= s4; req.sample_5 <= s5;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      speed_queue.push_back(predict_drive(s));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (speed_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (idx)
         CSR_GAIN_P:    gain_p_r = val;
         CSR_GAIN_I:    gain_i_r = val;
         CSR_GAIN_D:    gain_d_r = val;
         CSR_TIME_STEP: step_r = val;
         CSR_INV_STEP:  inv_step_r = val;
         CSR_MAX_SPEED: vmax_r = val[14:0];
         CSR_POS_MIN:   pmin_r = longint'($signed(val));
         CSR_POS_MAX:   pmax_r = longint'($signed(val));
         default: ;
      endcase
   endtask

   task automatic load_regs(logic [15:0] kp, ki, kd, ts, its, vm, pn, px);
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_TIME_STEP, ts);
      write_reg(CSR_INV_STEP, its);
      write_reg(CSR_MAX_SPEED, vm);
      write_reg(CSR_POS_MIN, pn);
      write_reg(CSR_POS_MAX, px);
      csr.valid <= 1'b0;
   endtask

   // a plausible frame: a line blob under one or two sensors, rest dark
   task automatic send_line_frame();
      logic [11:0] s[6];
      int c;
      c = $urandom_range(0, 5);
      for (int i = 0; i < 6; i++) s[i] = 12'($urandom_range(0, 120));
      s[c] = 12'($urandom_range(500, 4095));
      if (c < 5 && $urandom_range(0, 1)) s[c+1] = 12'($urandom_range(0, 4095));
      send_frame(s[0], s[1], s[2], s[3], s[4], s[5]);
   endtask

   task automatic send_noise_frame();
      send_frame(12'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom), 12'($urandom), 12'($urandom));
   endtask

   // ---- tests ----
   task automatic test_directed();
      send_frame(0, 0, 0, 0, 0, 0);                   // zero sum, centroid 0
      send_frame(4095, 0, 0, 0, 0, 0);                // far left
      send_frame(0, 0, 0, 0, 0, 4095);                // far right
      send_frame(0, 0, 1000, 1000, 0, 0);             // centered
      send_frame(4095, 4095, 4095, 4095, 4095, 4095); // lost line, prev > 0?
      send_frame(4095, 4095, 4095, 0, 0, 0);          // lost line again
      send_frame(0, 0, 0, 0, 0, 1);
      send_frame(1, 0, 0, 0, 0, 0);
      send_frame(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
      send_frame(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
      send_frame(2000, 2000, 2000, 2000, 2000, 1);    // sum just above limit
      send_frame(2000, 2000, 2000, 2000, 2000, 0);    // sum exactly at limit
      drain();
   endtask

   task automatic test_gains();
      // full gains, derivative and integral active
      load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF,
                16'h8000, 16'h7FFF);
      repeat (8) send_line_frame();
      send_frame(4095, 4095, 4095, 4095, 4095, 4095);
      drain();
      // zero gains, zero speed, equal positions
      load_regs(0, 0, 0, 0, 0, 0, 16'd500, 16'd500);
      repeat (6) send_line_frame();
      drain();
      // reversed positions and low max speed
      load_regs(16'd300, 16'd2000, 16'd40, 16'd655, 16'd100, 16'd1000,
                16'd3000, -16'sd3000);
      repeat (10) send_line_frame();
      drain();
   endtask

   task automatic test_random(int n);
      for (int k = 0; k < n; k++) begin
         if (k % 100 == 0) begin
            drain();
            load_regs(16'($urandom_range(0, 2048)), 16'($urandom), 16'($urandom_range(0, 64)),
                      16'($urandom), 16'($urandom_range(0, 1000)), 16'($urandom),
                      16'($urandom_range(0, 1) ? $urandom : -$urandom_range(1000, 4000)),
                      16'($urandom_range(1000, 4000)));
         end
         if ($urandom_range(0, 4) == 0) send_noise_frame();
         else send_line_frame();
      end
   endtask

   task automatic test_backpressure();
      // receiver held off while frames keep coming: the block fills and stalls
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            repeat (4) send_line_frame();
            req.valid <= 1'b0;
         end
      join
      drain();  // sender pauses until every drive has come back
   endtask

   // ---- response side ----
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (speed_queue.size() == 0) begin
            failed = 1'b1;
            if (mismatches++ < 10) $display("unexpected drive response");
         end else begin
            drive_out_t e;
            e = speed_queue.pop_front();
            if (e.left_speed !== rsp.left_speed || e.right_speed !== rsp.right_speed
                || e.line_error !== rsp.line_error) begin
               failed = 1'b1;
               if (mismatches++ < 10)
                  $display("drive mismatch: exp l=%0d r=%0d e=%0d got l=%0d r=%0d e=%0d",
                           e.left_speed, e.right_speed, e.line_error,
                           rsp.left_speed, rsp.right_speed, rsp.line_error);
            end
         end
      end
   end

   // receiver stalls in random bursts
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) rsp.ready <= 1'b0;
         else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp.ready <= !hold_rsp;
         end else rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      cycles = 0; mismatches = 0; failed = 1'b0; idle_on = 1'b1; hold_rsp = 1'b0;
      req.valid <= 1'b0;
      req.sample_0 <= '0; req.sample_1 <= '0; req.sample_2 <= '0;
      req.sample_3 <= '0; req.sample_4 <= '0; req.sample_5 <= '0;
      csr.valid <= 1'b0; csr.index <= CSR_GAIN_P; csr.data <= '0;
      gain_p_r = 256; gain_i_r = 0; gain_d_r = 0; step_r = 655; inv_step_r = 100;
      vmax_r = 16384; pmin_r = -3010; pmax_r = 3000;
      prev_err = 0; integ_acc = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_gains();
      test_backpressure();
      test_random(600);
      idle_on = 1'b0;   // closing stretch runs flat out
      test_random(100);
      drain();
      if (!failed && speed_queue.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
rtl/lfpd_pkg.sv
rtl/lfpd_if.sv
rtl/lfpd_divider.sv
rtl/lfpd_datapath.sv
rtl/lfpd_ctrl.sv
rtl/line_follower_pid_drive_top.sv
dv/tb.sv
